FILE: hw/rtl/priority_order_scheduler_assert.svh
// ----------------------------------------------------------------------------
// priority_order_scheduler assertion macros
// shared concurrent assertion forms for the scheduler rtl
// ----------------------------------------------------------------------------
`ifndef PRIORITY_ORDER_SCHEDULER_ASSERT_SVH
`define PRIORITY_ORDER_SCHEDULER_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define POS_ASSERT_IMPL(name, ck, rst_n, ante, cons) \
	name: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// next-cycle implication, disabled while in reset
`define POS_ASSERT_NEXT(name, ck, rst_n, ante, cons) \
	name: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

FILE: hw/rtl/pos_pkg.sv
// ----------------------------------------------------------------------------
// pos_pkg
// shared widths, job entry layout and controller/datapath interface structs
// ----------------------------------------------------------------------------
package pos_pkg;

	localparam int BURST_W = 16;
	localparam int PRIO_W  = 8;
	localparam int ID_W    = 5;
	localparam int TIME_W  = 20;

	// one stored job
	typedef struct packed {
		logic [PRIO_W-1:0]  prio;
		logic [BURST_W-1:0] burst;
		logic [ID_W-1:0]    id;
	} entry_t;

	// controller to datapath
	typedef struct packed {
		logic load;     // store the incoming request
		logic sort_go;  // incoming request closes the set
		logic scan;     // read one remaining entry
		logic pick;     // commit the maximum and emit a result
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic final_job;  // incoming request ends the set
		logic scan_end;   // current read is the last remaining entry
		logic pos_last;   // current position is the last of the set
	} sts_t;

endpackage

FILE: hw/rtl/priority_order_scheduler.sv
// ----------------------------------------------------------------------------
// priority_order_scheduler
// non-preemptive priority scheduler: load jobs, sort by priority, emit times
// ----------------------------------------------------------------------------
// loading: one request per cycle while busy is low, no result for non-final jobs
// final request of n jobs: busy is high from then until the pick of the last result
// for each position p the scan state reads the remaining jobs through the one memory read
// port, then the pick state commits their maximum and registers its result
// results are one-cycle strobes that cannot be stalled
// reset clears the job count, scan counters and the strobe; the job memory is not cleared

module priority_order_scheduler #(
	parameter int MAX_PROCS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,

	// request side
	input  logic                          start,
	output logic                          busy,
	input  logic [pos_pkg::BURST_W-1:0]   burst_time,
	input  logic [pos_pkg::PRIO_W-1:0]    priority_req,
	input  logic                          last_process,

	// result side
	output logic                          result_valid,
	output logic [pos_pkg::ID_W-1:0]      process_id,
	output logic [pos_pkg::BURST_W-1:0]   burst_out,
	output logic [pos_pkg::TIME_W-1:0]    start_time,
	output logic [pos_pkg::TIME_W-1:0]    finish_time,
	output logic                          last_result
);

	// command and status between sequencer and datapath
	pos_pkg::cmd_t cmd;
	pos_pkg::sts_t sts;

	// sequencer: idle takes requests, scan walks the unsorted tail,
	// pick commits the maximum of that tail and emits its result
	pos_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.busy   (busy),
		.cmd    (cmd)
	);

	// datapath: job memory (one write, one registered read port),
	// running maximum compare, start/finish accumulator, result registers
	pos_dp #(
		.MAX_PROCS (MAX_PROCS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.burst_time   (burst_time),
		.priority_req (priority_req),
		.last_process (last_process),
		.cmd          (cmd),
		.sts          (sts),
		.process_id   (process_id),
		.burst_out    (burst_out),
		.start_time   (start_time),
		.finish_time  (finish_time),
		.last_result  (last_result),
		.result_valid (result_valid)
	);

endmodule

FILE: hw/rtl/pos_dp.sv
// ----------------------------------------------------------------------------
// pos_dp
// job memory, selection scan with running maximum, and result registers
// ----------------------------------------------------------------------------
`include "priority_order_scheduler_assert.svh"

module pos_dp #(
	parameter int MAX_PROCS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [pos_pkg::BURST_W-1:0]   burst_time,
	input  logic [pos_pkg::PRIO_W-1:0]    priority_req,
	input  logic                          last_process,
	input  pos_pkg::cmd_t                 cmd,
	output pos_pkg::sts_t                 sts,
	output logic [pos_pkg::ID_W-1:0]      process_id,
	output logic [pos_pkg::BURST_W-1:0]   burst_out,
	output logic [pos_pkg::TIME_W-1:0]    start_time,
	output logic [pos_pkg::TIME_W-1:0]    finish_time,
	output logic                          last_result,
	output logic                          result_valid
);

	localparam int AW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
	localparam int CW = $clog2(MAX_PROCS + 1);
	localparam logic [CW-1:0] MAX_CNT = CW'(MAX_PROCS);

	pos_pkg::entry_t mem [MAX_PROCS];

	pos_pkg::entry_t rd_s1;
	logic [AW-1:0]   idx_s1;
	logic            v_s1;
	logic            first_s1;

	logic [CW-1:0]   cnt_q;
	logic [CW-1:0]   n_q;
	logic [AW-1:0]   pos_q;
	logic [AW-1:0]   k_q;
	logic [pos_pkg::TIME_W-1:0] time_q;

	pos_pkg::entry_t best_q;
	logic [AW-1:0]   best_idx_q;
	pos_pkg::entry_t pos_ent_q;

	logic [pos_pkg::ID_W-1:0]    process_id_q;
	logic [pos_pkg::BURST_W-1:0] burst_out_q;
	logic [pos_pkg::TIME_W-1:0]  start_time_q;
	logic [pos_pkg::TIME_W-1:0]  finish_time_q;
	logic                        last_result_q;
	logic                        result_valid_q;

	pos_pkg::entry_t nb;
	logic [AW-1:0]   nb_idx;
	pos_pkg::entry_t pos_ent;
	pos_pkg::entry_t wr_data;
	logic [AW-1:0]   wr_addr;
	logic            we;
	logic [CW-1:0]   cnt_inc;
	logic [pos_pkg::TIME_W-1:0] time_nxt;

	assign cnt_inc  = cnt_q + CW'(1);
	assign time_nxt = time_q + pos_pkg::TIME_W'(nb.burst);

	assign sts.final_job = last_process || (cnt_inc == MAX_CNT);
	assign sts.scan_end  = (CW'(k_q) + CW'(1)) == n_q;
	assign sts.pos_last  = (CW'(pos_q) + CW'(1)) == n_q;

	// running maximum, first strict maximum wins
	always_comb begin
		if (first_s1 || (rd_s1.prio > best_q.prio)) begin
			nb     = rd_s1;
			nb_idx = idx_s1;
		end else begin
			nb     = best_q;
			nb_idx = best_idx_q;
		end
		pos_ent = first_s1 ? rd_s1 : pos_ent_q;
	end

	// write port: load a new job, or move the displaced job into the max slot
	always_comb begin
		we = cmd.load || cmd.pick;
		if (cmd.load) begin
			wr_addr       = cnt_q[AW-1:0];
			wr_data.prio  = priority_req;
			wr_data.burst = burst_time;
			wr_data.id    = pos_pkg::ID_W'(cnt_inc);
		end else begin
			wr_addr = nb_idx;
			wr_data = pos_ent;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_s1  <= mem[k_q];
		idx_s1 <= k_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			first_s1 <= 1'b0;
		end else begin
			v_s1     <= cmd.scan;
			first_s1 <= cmd.scan && (k_q == pos_q);
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			best_q     <= nb;
			best_idx_q <= nb_idx;
		end
		if (first_s1) begin
			pos_ent_q <= rd_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			n_q    <= '0;
			pos_q  <= '0;
			k_q    <= '0;
			time_q <= '0;
		end else begin
			if (cmd.load) begin
				if (cmd.sort_go) begin
					n_q    <= cnt_inc;
					cnt_q  <= '0;
					pos_q  <= '0;
					k_q    <= '0;
					time_q <= '0;
				end else begin
					cnt_q <= cnt_inc;
				end
			end
			if (cmd.scan) begin
				k_q <= k_q + AW'(1);
			end
			if (cmd.pick) begin
				pos_q  <= pos_q + AW'(1);
				k_q    <= pos_q + AW'(1);
				time_q <= time_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pick) begin
			process_id_q  <= nb.id;
			burst_out_q   <= nb.burst;
			start_time_q  <= time_q;
			finish_time_q <= time_nxt;
			last_result_q <= sts.pos_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= cmd.pick;
		end
	end

	assign process_id   = process_id_q;
	assign burst_out    = burst_out_q;
	assign start_time   = start_time_q;
	assign finish_time  = finish_time_q;
	assign last_result  = last_result_q;
	assign result_valid = result_valid_q;

	`POS_ASSERT_NEXT(a_pick_emits, clk, arst_n, cmd.pick, result_valid_q)
	`POS_ASSERT_IMPL(a_scan_in_set, clk, arst_n, cmd.scan, CW'(k_q) < n_q)
	`POS_ASSERT_NEXT(a_close_clears_count, clk, arst_n, cmd.load && cmd.sort_go, cnt_q == '0)

endmodule

FILE: hw/rtl/pos_ctrl.sv
// ----------------------------------------------------------------------------
// pos_ctrl
// sequencer for load, scan and pick phases of the scheduler
// ----------------------------------------------------------------------------
`include "priority_order_scheduler_assert.svh"

module pos_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  pos_pkg::sts_t sts,
	output logic          busy,
	output pos_pkg::cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_PICK = 3'b100
	} state_t;

	state_t state_q;
	state_t state_nxt;

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load    = 1'b1;
					cmd.sort_go = sts.final_job;
					if (sts.final_job) begin
						state_nxt = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.scan_end) begin
					state_nxt = ST_PICK;
				end
			end
			ST_PICK: begin
				cmd.pick  = 1'b1;
				state_nxt = sts.pos_last ? ST_IDLE : ST_SCAN;
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign busy = (state_q != ST_IDLE);

	`POS_ASSERT_NEXT(a_scan_to_pick, clk, arst_n, state_q == ST_SCAN && sts.scan_end, state_q == ST_PICK)

endmodule
